// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL; empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASRT_CLKRST(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) else $error(msg);

`define ASRT_CLK(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) (prop)) else $error(msg);

`else

`define ASRT_CLKRST(lbl, clk_s, rst_s, prop, msg)

`define ASRT_CLK(lbl, clk_s, prop, msg)

`endif

`endif

// ----- hdl/obrb_pkg.sv -----
// Types and constants of the overwriting byte ring buffer.
package obrb_pkg;

  localparam int DEPTH_DEF     = 1024;
  localparam int RING_SIZE_W   = 11;
  localparam int RING_SIZE_RST = 1024;
  localparam int ACTION_W      = 3;
  localparam int DATA_W        = 8;
  localparam int OFFSET_W      = 10;
  localparam int FILL_W        = 10;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE   = 3'd0,
    ACT_READ    = 3'd1,
    ACT_LOOK    = 3'd2,
    ACT_FLUSH   = 3'd3,
    ACT_CLR_ERR = 3'd4
  } action_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [DATA_W-1:0]   data_in;
    logic [OFFSET_W-1:0] look_offset;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic              data_valid;
    logic [FILL_W-1:0] fill_count;
    logic              is_empty;
    logic              overflow_seen;
  } out_item_t;

  typedef struct packed {
    logic              data_valid;
    logic [FILL_W-1:0] fill_count;
    logic              is_empty;
    logic              overflow_seen;
  } status_t;

endpackage

// ----- hdl/obrb_ram.sv -----
// Byte store: one write port, one read port with registered read data.
module obrb_ram #(
  parameter int DEPTH = obrb_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  logic [obrb_pkg::DATA_W-1:0]   wr_data,
  input  logic                          rd_en,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr,
  output logic [obrb_pkg::DATA_W-1:0]   rd_data
);

  logic [obrb_pkg::DATA_W-1:0] mem [DEPTH];
  logic [obrb_pkg::DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/obrb_ctrl.sv -----
// Ring indices, overflow flag, active size and per-transaction status.
module obrb_ctrl #(
  parameter int DEPTH = obrb_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                go,
  input  obrb_pkg::in_item_t                  item,
  input  logic                                cfg_wr_en,
  input  logic [obrb_pkg::RING_SIZE_W-1:0]    cfg_wr_data,
  output logic                                ram_we,
  output logic [$clog2(DEPTH)-1:0]            ram_waddr,
  output logic [obrb_pkg::DATA_W-1:0]         ram_wdata,
  output logic                                ram_re,
  output logic [$clog2(DEPTH)-1:0]            ram_raddr,
  output obrb_pkg::status_t                   status
);

  localparam int IW = $clog2(DEPTH);
  localparam int SW = IW + 1;
  localparam int CW = (SW > obrb_pkg::RING_SIZE_W) ? SW : obrb_pkg::RING_SIZE_W;
  localparam int PW = ((SW > obrb_pkg::OFFSET_W) ? SW : obrb_pkg::OFFSET_W) + 1;
  localparam logic [SW-1:0] SIZE_RST = (obrb_pkg::RING_SIZE_RST > DEPTH) ?
                                       SW'(DEPTH) : SW'(obrb_pkg::RING_SIZE_RST);

  logic [IW-1:0] rd_r, rd_nxt;
  logic [IW-1:0] wr_r, wr_nxt;
  logic          ovf_r, ovf_nxt;
  logic [SW-1:0] size_r, size_nxt;
  logic [CW-1:0] cfg_ext;
  logic [SW-1:0] held_cur;
  logic [PW-1:0] pos, pos_wrap;
  logic          hit;
  logic          we;

  function automatic logic [IW-1:0] adv(input logic [IW-1:0] idx, input logic [SW-1:0] sz);
    logic [SW-1:0] inc;
    inc = SW'(idx) + SW'(1);
    adv = (inc == sz) ? '0 : IW'(inc);
  endfunction

  function automatic logic [SW-1:0] held(input logic [IW-1:0] rd, input logic [IW-1:0] wr,
                                         input logic [SW-1:0] sz);
    if (wr >= rd) begin
      held = SW'(wr) - SW'(rd);
    end else begin
      held = SW'(wr) + sz - SW'(rd);
    end
  endfunction

  // clamp written size to 2..DEPTH
  always_comb begin
    cfg_ext = CW'(cfg_wr_data);
    if (cfg_ext < CW'(2)) begin
      size_nxt = SW'(2);
    end else if (cfg_ext > CW'(DEPTH)) begin
      size_nxt = SW'(DEPTH);
    end else begin
      size_nxt = SW'(cfg_ext);
    end
  end

  always_comb begin
    rd_nxt   = rd_r;
    wr_nxt   = wr_r;
    ovf_nxt  = ovf_r;
    hit      = 1'b0;
    we       = 1'b0;
    held_cur = held(rd_r, wr_r, size_r);
    pos      = PW'(rd_r) + PW'(item.look_offset);
    pos_wrap = (pos >= PW'(size_r)) ? pos - PW'(size_r) : pos;
    ram_raddr = rd_r;
    unique case (obrb_pkg::action_t'(item.action))
      obrb_pkg::ACT_WRITE: begin
        we     = 1'b1;
        wr_nxt = adv(wr_r, size_r);
        if (wr_nxt == rd_r) begin
          rd_nxt  = adv(rd_r, size_r);
          ovf_nxt = 1'b1;
        end
      end
      obrb_pkg::ACT_READ: begin
        if (rd_r != wr_r) begin
          hit    = 1'b1;
          rd_nxt = adv(rd_r, size_r);
        end
      end
      obrb_pkg::ACT_LOOK: begin
        ram_raddr = IW'(pos_wrap);
        if (PW'(item.look_offset) < PW'(held_cur)) begin
          hit = 1'b1;
        end
      end
      obrb_pkg::ACT_FLUSH: begin
        rd_nxt = '0;
        wr_nxt = '0;
      end
      obrb_pkg::ACT_CLR_ERR: begin
        ovf_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign ram_we    = go & we;
  assign ram_waddr = wr_r;
  assign ram_wdata = item.data_in;
  assign ram_re    = go & hit;

  assign status.data_valid    = hit;
  assign status.fill_count    = obrb_pkg::FILL_W'(held(rd_nxt, wr_nxt, size_r));
  assign status.is_empty      = (rd_nxt == wr_nxt);
  assign status.overflow_seen = ovf_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r   <= '0;
      wr_r   <= '0;
      ovf_r  <= 1'b0;
      size_r <= SIZE_RST;
    end else if (cfg_wr_en) begin
      size_r <= size_nxt;
      rd_r   <= '0;
      wr_r   <= '0;
    end else if (go) begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

// ----- hdl/overwriting_byte_ring_buffer.sv -----
// Overwriting byte ring buffer, top level.
//
// Input channel in_valid/in_stall/in_item carries one action per transaction:
// write, read, look, flush or clear error. Every transaction yields exactly one
// result on out_valid/out_stall/out_item with the byte (if any), the fill count,
// empty and the sticky overflow flag as they stand after that action.
// Throughput: one transaction per cycle while the receiver does not stall.
// The input register feeds the index logic and the byte store read port; the
// registered read data and the status register form the result stage.
// When the receiver stalls, the result holds and one more transaction may sit
// in the input register; after that in_stall rises.
// Reset (rst_n low, synchronous) empties the ring, clears the flag and sets the
// size to 1024 slots (or DEPTH if smaller). Store contents are not cleared.
// cfg_wr_en writes ring_size (clamped to 2..DEPTH) and empties the ring; write
// it only while no transaction is in flight.
`include "assert_macros.svh"

module overwriting_byte_ring_buffer #(
  parameter int DEPTH = obrb_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  obrb_pkg::in_item_t                in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output obrb_pkg::out_item_t               out_item,
  input  logic                              cfg_wr_en,
  input  logic [obrb_pkg::RING_SIZE_W-1:0]  cfg_wr_data
);

  localparam int IW = $clog2(DEPTH);
  localparam bit FILL_FITS = (DEPTH <= (1 << obrb_pkg::FILL_W));

  logic                        a_vld_r, a_vld_nxt;
  obrb_pkg::in_item_t          a_item_r;
  logic                        b_vld_r, b_vld_nxt;
  obrb_pkg::status_t           b_stat_r;
  obrb_pkg::status_t           stat;
  logic                        accept;
  logic                        move_b;
  logic                        ram_we, ram_re;
  logic [IW-1:0]               ram_waddr, ram_raddr;
  logic [obrb_pkg::DATA_W-1:0] ram_wdata, ram_rdata;
  logic                        out_empty_ok;

  assign move_b    = a_vld_r & ~(b_vld_r & out_stall);
  assign in_stall  = a_vld_r & b_vld_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign a_vld_nxt = accept | (a_vld_r & ~move_b);
  assign b_vld_nxt = move_b | (b_vld_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= a_vld_nxt;
      b_vld_r <= b_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_item_r <= in_item;
    end
    if (move_b) begin
      b_stat_r <= stat;
    end
  end

  obrb_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (move_b),
    .item        (a_item_r),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .status      (stat)
  );

  obrb_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign out_valid              = b_vld_r;
  assign out_item.data_out      = b_stat_r.data_valid ? ram_rdata : '0;
  assign out_item.data_valid    = b_stat_r.data_valid;
  assign out_item.fill_count    = b_stat_r.fill_count;
  assign out_item.is_empty      = b_stat_r.is_empty;
  assign out_item.overflow_seen = b_stat_r.overflow_seen;

  assign out_empty_ok = !FILL_FITS || (out_item.is_empty == (out_item.fill_count == '0));

  // assertions
  `ASRT_CLKRST(a_stall_needs_item, clk, rst_n, in_stall |-> a_vld_r, "stall while input empty")
  `ASRT_CLKRST(a_item_kept, clk, rst_n, (a_vld_r && in_stall) |=> a_vld_r, "held transaction lost")
  `ASRT_CLKRST(b_empty_fill, clk, rst_n, out_valid |-> out_empty_ok, "empty flag vs fill count")

endmodule

// ----- sim/testbench.sv -----
// Testbench for overwriting_byte_ring_buffer: directed and random actions checked by a predictor.
`timescale 1ns / 100ps

module testbench;

  localparam logic [obrb_pkg::ACTION_W-1:0] ACT_NONE_FIRST = 3'd5;
  localparam logic [obrb_pkg::ACTION_W-1:0] ACT_NONE_LAST  = 3'd7;
  localparam int RING_SLOTS   = obrb_pkg::DEPTH_DEF;
  localparam int MIN_RING     = 2;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int MAX_REPORTED = 10;

  logic                             clk         = 1'b0;
  logic                             rst_n       = 1'b0;
  logic                             in_valid    = 1'b0;
  logic                             in_stall;
  obrb_pkg::in_item_t               in_item     = '0;
  logic                             out_valid;
  logic                             out_stall   = 1'b0;
  obrb_pkg::out_item_t              out_item;
  logic                             cfg_wr_en   = 1'b0;
  logic [obrb_pkg::RING_SIZE_W-1:0] cfg_wr_data = '0;

  // predicted ring state
  logic [obrb_pkg::DATA_W-1:0]      ring_bytes [RING_SLOTS];
  int                               rd_idx        = 0;
  int                               wr_idx        = 0;
  bit                               ring_ovf      = 1'b0;
  logic [obrb_pkg::RING_SIZE_W-1:0] ring_size_reg =
    obrb_pkg::RING_SIZE_W'(obrb_pkg::RING_SIZE_RST);

  obrb_pkg::out_item_t pending_results[$];
  int                  mismatches  = 0;
  int                  idle_cycles = 0;
  int                  tx_max_gap  = 15;
  int                  rx_max_gap  = 15;
  int                  rx_hold_len = 0;

  overwriting_byte_ring_buffer u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int active_size();
    if (ring_size_reg < MIN_RING) return MIN_RING;
    if (ring_size_reg > RING_SLOTS) return RING_SLOTS;
    return int'(ring_size_reg);
  endfunction

  function automatic int next_index(int idx);
    return (idx + 1 >= active_size()) ? 0 : idx + 1;
  endfunction

  function automatic int ring_fill();
    return (wr_idx >= rd_idx) ? wr_idx - rd_idx : wr_idx + active_size() - rd_idx;
  endfunction

  function automatic obrb_pkg::out_item_t predict_ring_result(obrb_pkg::in_item_t it);
    obrb_pkg::out_item_t res;
    int                  pos;
    res = '0;
    case (it.action)
      obrb_pkg::ACT_WRITE: begin
        ring_bytes[wr_idx] = it.data_in;
        wr_idx = next_index(wr_idx);
        if (wr_idx == rd_idx) begin
          rd_idx = next_index(rd_idx);
          ring_ovf = 1'b1;
        end
      end
      obrb_pkg::ACT_READ: begin
        if (rd_idx != wr_idx) begin
          res.data_out = ring_bytes[rd_idx];
          res.data_valid = 1'b1;
          rd_idx = next_index(rd_idx);
        end
      end
      obrb_pkg::ACT_LOOK: begin
        if (int'(it.look_offset) < ring_fill()) begin
          pos = rd_idx + int'(it.look_offset);
          if (pos >= active_size()) pos -= active_size();
          res.data_out = ring_bytes[pos];
          res.data_valid = 1'b1;
        end
      end
      obrb_pkg::ACT_FLUSH: begin
        rd_idx = 0;
        wr_idx = 0;
      end
      obrb_pkg::ACT_CLR_ERR: begin
        ring_ovf = 1'b0;
      end
      default: begin
      end
    endcase
    res.fill_count = obrb_pkg::FILL_W'(ring_fill());
    res.is_empty = (rd_idx == wr_idx);
    res.overflow_seen = ring_ovf;
    return res;
  endfunction

  function automatic obrb_pkg::in_item_t make_item(logic [obrb_pkg::ACTION_W-1:0] act,
                                                   logic [obrb_pkg::DATA_W-1:0] data,
                                                   logic [obrb_pkg::OFFSET_W-1:0] offset);
    obrb_pkg::in_item_t it;
    it.action = act;
    it.data_in = data;
    it.look_offset = offset;
    return it;
  endfunction

  // mostly well-formed traffic: looks usually land inside the held bytes
  function automatic obrb_pkg::in_item_t random_item();
    obrb_pkg::in_item_t it;
    int                 fill;
    int                 pick;
    fill = ring_fill();
    pick = $urandom_range(0, 99);
    it.data_in = obrb_pkg::DATA_W'($urandom_range(0, 255));
    it.look_offset = obrb_pkg::OFFSET_W'($urandom_range(0, RING_SLOTS - 1));
    if (pick < 42) begin
      it.action = obrb_pkg::ACT_WRITE;
    end else if (pick < 67) begin
      it.action = obrb_pkg::ACT_READ;
    end else if (pick < 85) begin
      it.action = obrb_pkg::ACT_LOOK;
      if (fill > 0 && $urandom_range(0, 4) != 0) begin
        it.look_offset = obrb_pkg::OFFSET_W'($urandom_range(0, fill - 1));
      end
    end else if (pick < 89) begin
      it.action = obrb_pkg::ACT_FLUSH;
    end else if (pick < 95) begin
      it.action = obrb_pkg::ACT_CLR_ERR;
    end else begin
      it.action = obrb_pkg::ACTION_W'($urandom_range(ACT_NONE_FIRST, ACT_NONE_LAST));
    end
    return it;
  endfunction

  function automatic string show_result(obrb_pkg::out_item_t r);
    return $sformatf("data %h valid %b fill %0d empty %b overflow %b",
                     r.data_out, r.data_valid, r.fill_count, r.is_empty, r.overflow_seen);
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_REPORTED) $display("%0t: %s", $time, what);
  endtask

  task automatic send_item(obrb_pkg::in_item_t it);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_ring_result(it));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_ring_size(logic [obrb_pkg::RING_SIZE_W-1:0] value);
    drain_results();
    cfg_wr_data <= value;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    ring_size_reg = value;
    rd_idx = 0;
    wr_idx = 0;
  endtask

  task automatic test_reset_state();
    send_item(make_item(obrb_pkg::ACT_READ, 8'h00, 10'd0));
    send_item(make_item(obrb_pkg::ACT_LOOK, 8'h00, 10'd0));
    send_item(make_item(obrb_pkg::ACT_LOOK, 8'hFF, 10'h3FF));
    send_item(make_item(ACT_NONE_LAST, 8'hFF, 10'h3FF));
    send_item(make_item(obrb_pkg::ACT_WRITE, 8'h00, 10'h3FF));
    send_item(make_item(obrb_pkg::ACT_WRITE, 8'hFF, 10'd0));
    send_item(make_item(obrb_pkg::ACT_LOOK, 8'h00, 10'd1));
    send_item(make_item(obrb_pkg::ACT_LOOK, 8'h00, 10'd2));
    send_item(make_item(obrb_pkg::ACT_READ, 8'h00, 10'd0));
    send_item(make_item(obrb_pkg::ACT_READ, 8'h00, 10'd0));
    send_item(make_item(obrb_pkg::ACT_READ, 8'h00, 10'd0));
    send_item(make_item(obrb_pkg::ACT_CLR_ERR, 8'h00, 10'd0));
  endtask

  // size 0 and 1 both act as two slots; the flag survives a size change
  task automatic test_two_slot_ring();
    write_ring_size(11'd0);
    send_item(make_item(obrb_pkg::ACT_WRITE, 8'hA5, 10'd0));
    send_item(make_item(obrb_pkg::ACT_WRITE, 8'h5A, 10'd0));
    send_item(make_item(obrb_pkg::ACT_LOOK, 8'h00, 10'd0));
    send_item(make_item(obrb_pkg::ACT_READ, 8'h00, 10'd0));
    send_item(make_item(obrb_pkg::ACT_WRITE, 8'h3C, 10'd0));
    send_item(make_item(obrb_pkg::ACT_FLUSH, 8'h00, 10'd0));
    send_item(make_item(obrb_pkg::ACT_READ, 8'h00, 10'd0));
    write_ring_size(11'd1);
    send_item(make_item(ACT_NONE_FIRST, 8'h00, 10'd0));
    send_item(make_item(obrb_pkg::ACT_CLR_ERR, 8'h00, 10'd0));
    send_item(make_item(obrb_pkg::ACT_WRITE, 8'h01, 10'd0));
    send_item(make_item(obrb_pkg::ACT_WRITE, 8'h02, 10'd0));
  endtask

  task automatic test_full_ring();
    int i;
    write_ring_size('1);
    tx_max_gap = 0;
    rx_max_gap = 0;
    for (i = 0; i < RING_SLOTS + 6; i++) begin
      if (i == RING_SLOTS / 2) begin
        tx_max_gap = 15;
        rx_max_gap = 15;
      end
      send_item(make_item(obrb_pkg::ACT_WRITE, obrb_pkg::DATA_W'($urandom_range(0, 255)),
                          obrb_pkg::OFFSET_W'($urandom_range(0, RING_SLOTS - 1))));
    end
    send_item(make_item(obrb_pkg::ACT_LOOK, 8'h00, obrb_pkg::OFFSET_W'(RING_SLOTS - 2)));
    send_item(make_item(obrb_pkg::ACT_LOOK, 8'h00, obrb_pkg::OFFSET_W'(RING_SLOTS - 1)));
    send_item(make_item(obrb_pkg::ACT_LOOK, 8'h00, 10'd0));
    repeat (4) send_item(make_item(obrb_pkg::ACT_READ, 8'h00, 10'd0));
    send_item(make_item(obrb_pkg::ACT_CLR_ERR, 8'h00, 10'd0));
  endtask

  task automatic test_backpressure();
    write_ring_size(11'd16);
    tx_max_gap = 0;
    rx_max_gap = 0;
    rx_hold_len = 300;
    repeat (60) send_item(random_item());
    drain_results();
  endtask

  task automatic test_random_traffic();
    int phase;
    int n;
    int size;
    for (phase = 0; phase < 12; phase++) begin
      if (phase == 0) begin
        size = obrb_pkg::RING_SIZE_RST;
      end else if ($urandom_range(0, 3) == 0) begin
        size = $urandom_range(41, 1500);
      end else begin
        size = $urandom_range(MIN_RING, 40);
      end
      write_ring_size(obrb_pkg::RING_SIZE_W'(size));
      tx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 15;
      rx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 15;
      for (n = 0; n < 48; n++) begin
        if (n == 24 && $urandom_range(0, 1) == 1) drain_results();
        send_item(random_item());
      end
    end
  endtask

  initial begin : result_receiver
    int hold;
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_len > 0) begin
        hold = rx_hold_len;
        rx_hold_len = 0;
      end else begin
        hold = $urandom_range(0, rx_max_gap);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : check_results
    obrb_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch({"unexpected result: ", show_result(out_item)});
      end else begin
        want = pending_results.pop_front();
        if (out_item.data_out !== want.data_out || out_item.data_valid !== want.data_valid ||
            out_item.fill_count !== want.fill_count || out_item.is_empty !== want.is_empty ||
            out_item.overflow_seen !== want.overflow_seen) begin
          report_mismatch({"expected ", show_result(want), " got ", show_result(out_item)});
        end
      end
    end
  end

  // no transaction for too long means the block hung
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("overwriting_byte_ring_buffer test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_two_slot_ring();
    test_full_ring();
    test_backpressure();
    test_random_traffic();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("overwriting_byte_ring_buffer test passed");
    end else begin
      $display("overwriting_byte_ring_buffer test failed");
    end
    $finish;
  end

endmodule
